[rtl/core/jet_pkg.sv]
// Shared types, widths and helpers of the Julia escape-time pixel evaluator.
`timescale 1ns / 1ps

package jet_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int SHADE_LEVELS  = 16;

   localparam int COORD_W    = $clog2(MAX_DIMENSION);
   localparam int DIM_W      = COORD_W + 1;
   localparam int OFF_W      = DIM_W + 1;
   localparam int CONST_W    = 28;
   localparam int RADIUS_W   = 29;
   localparam int ITER_W     = 16;
   localparam int SHADE_W    = $clog2(SHADE_LEVELS);
   localparam int FRAC_BITS  = 26;
   localparam int Q_W        = 32;
   localparam int PROD_W     = 2 * Q_W;
   localparam int LIMIT_W    = 2 * RADIUS_W;
   localparam int SUM_W      = 40;
   localparam int DIVIDEND_W = DIM_W + RADIUS_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RADIUS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_RADIUS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd5;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef logic signed [Q_W-1:0]    q_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // Clamps a widened sum back into the signed Q6.26 range.
   function automatic q_type sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W-Q_W){1'b0}}, Q_MAX};
      lo = {{(SUM_W-Q_W){1'b1}}, Q_MIN};
      if (v > hi) begin
         return Q_MAX;
      end else if (v < lo) begin
         return Q_MIN;
      end
      return v[Q_W-1:0];
   endfunction

endpackage

[rtl/core/jet_mul.sv]
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
`timescale 1ns / 1ps

module jet_mul
   import jet_pkg::*;
(
   input  logic     clock,
   input  logic     mul_en,
   input  q_type    op_a,
   input  q_type    op_b,
   output prod_type prod
);

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

[rtl/core/jet_div.sv]
// Restoring divider, one quotient bit per cycle, for the pixel mapping.
`timescale 1ns / 1ps

module jet_div
   import jet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIM_W-1:0]      divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIM_W-1:0]      rem_ff, rem_in;
   logic [DIM_W:0]        trial;
   logic                  fits;

   // The partial remainder stays below the divisor, so one extra bit suffices.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/julia_escape_time_pixel.sv]
// Top level of the Julia escape-time pixel evaluator: registers, sequencer and result stage.
`timescale 1ns / 1ps

// Each request maps one pixel onto the complex plane and iterates z = z*z + c in signed
// Q6.26 until |z| passes the escape radius or the iteration limit is reached. One request
// is in work at a time. Each iteration uses the single shared 32 by 32 multiplier three
// times plus an update step, and the mapping runs the 42-step divider once per axis.
// A finished result waits in the output register while the next request is taken.
module julia_escape_time_pixel
   import jet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_W-1:0]    req_pixel_x,
   input  logic [COORD_W-1:0]    req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SHADE_W-1:0]    rsp_shade,
   output logic                  rsp_escaped,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_LIMIT     = 10'b00_0000_0010,
      S_MAP_MUL   = 10'b00_0000_0100,
      S_DIV_START = 10'b00_0000_1000,
      S_DIV_WAIT  = 10'b00_0001_0000,
      S_MUL_RR    = 10'b00_0010_0000,
      S_MUL_II    = 10'b00_0100_0000,
      S_MUL_RI    = 10'b00_1000_0000,
      S_UPDATE    = 10'b01_0000_0000,
      S_FINISH    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]          width_ff, height_ff;
   logic signed [CONST_W-1:0] c_real_ff, c_imag_ff;
   logic [RADIUS_W-1:0]       radius_ff;
   logic [ITER_W-1:0]         max_iter_ff;

   logic [COORD_W-1:0] px_ff, px_in;
   logic [COORD_W-1:0] py_ff, py_in;
   logic               axis_ff, axis_in;
   logic               first_ff, first_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   q_type              zr_ff, zr_in;
   q_type              zi_ff, zi_in;
   prod_type           sqr_ff, sqr_in;
   prod_type           sqi_ff, sqi_in;
   logic [SHADE_W-1:0] res_shade_ff, res_shade_in;
   logic               res_esc_ff, res_esc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SHADE_W-1:0] rsp_shade_ff, rsp_shade_in;
   logic               rsp_esc_ff, rsp_esc_in;

   logic                  mul_en;
   q_type                 op_a, op_b;
   prod_type              prod;
   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic [DIM_W-1:0]        span;
   logic [COORD_W-1:0]      coord;
   logic [DIM_W-1:0]        dim;
   logic signed [OFF_W-1:0] off;
   logic                    off_neg;
   logic [DIM_W-1:0]        off_mag;
   logic                    q_big;
   q_type                   mapped;
   prod_type                diff, re_shift, im_shift;
   logic signed [SUM_W-1:0] re_sum, im_sum;
   logic [PROD_W-1:0]       mag_sum;
   logic                    escape_hit;
   logic                    out_free;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_W'(1920);
         height_ff   <= DIM_W'(1080);
         c_real_ff   <= -CONST_W'(47092974);
         c_imag_ff   <= CONST_W'(10468983);
         radius_ff   <= RADIUS_W'(80530637);
         max_iter_ff <= ITER_W'(500);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:    width_ff    <= csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   height_ff   <= csr_write_data[DIM_W-1:0];
            CSR_C_REAL:         c_real_ff   <= csr_write_data[CONST_W-1:0];
            CSR_C_IMAG:         c_imag_ff   <= csr_write_data[CONST_W-1:0];
            CSR_ESCAPE_RADIUS:  radius_ff   <= csr_write_data[RADIUS_W-1:0];
            CSR_MAX_ITERATIONS: max_iter_ff <= csr_write_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // Mapping: offset from the frame center, scaled by twice the radius over the smaller side.
   always_comb begin
      if (width_ff < height_ff) begin
         span = width_ff;
      end else begin
         span = height_ff;
      end
      if (span == '0) begin
         span = DIM_W'(1);
      end
   end

   assign coord   = axis_ff ? py_ff : px_ff;
   assign dim     = axis_ff ? height_ff : width_ff;
   assign off     = $signed({1'b0, coord, 1'b0}) - $signed({1'b0, dim});
   assign off_neg = off[OFF_W-1];
   assign off_mag = off_neg ? DIM_W'(-off) : off[DIM_W-1:0];

   assign q_big = |div_quotient[DIVIDEND_W-1:Q_W-1];
   always_comb begin
      if (off_neg) begin
         mapped = q_big ? Q_MIN : -$signed(div_quotient[Q_W-1:0]);
      end else begin
         mapped = q_big ? Q_MAX : $signed(div_quotient[Q_W-1:0]);
      end
   end

   // Iteration update: products are floored back to Q6.26, the cross term doubled.
   assign diff     = sqr_ff - sqi_ff;
   assign re_shift = diff >>> FRAC_BITS;
   assign im_shift = prod >>> (FRAC_BITS - 1);
   assign re_sum   = $signed(re_shift[SUM_W-1:0])
                     + $signed({{(SUM_W-CONST_W){c_real_ff[CONST_W-1]}}, c_real_ff});
   assign im_sum   = $signed(im_shift[SUM_W-1:0])
                     + $signed({{(SUM_W-CONST_W){c_imag_ff[CONST_W-1]}}, c_imag_ff});

   // Both squares are non-negative, so their sum fits the unsigned product width.
   assign mag_sum    = sqr_ff + prod;
   assign escape_hit = mag_sum > {{(PROD_W-LIMIT_W){1'b0}}, limit_ff};

   always_comb begin
      unique case (state_ff)
         S_LIMIT: begin
            op_a = {{(Q_W-RADIUS_W){1'b0}}, radius_ff};
            op_b = {{(Q_W-RADIUS_W){1'b0}}, radius_ff};
         end
         S_MAP_MUL: begin
            op_a = {{(Q_W-DIM_W){1'b0}}, off_mag};
            op_b = {{(Q_W-RADIUS_W){1'b0}}, radius_ff};
         end
         S_MUL_RR: begin
            op_a = zr_ff;
            op_b = zr_ff;
         end
         S_MUL_II: begin
            op_a = zi_ff;
            op_b = zi_ff;
         end
         S_MUL_RI: begin
            op_a = zr_ff;
            op_b = zi_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mul_en = (state_ff == S_LIMIT) || (state_ff == S_MAP_MUL) || (state_ff == S_MUL_RR)
                   || (state_ff == S_MUL_II) || (state_ff == S_MUL_RI);
   assign div_start = (state_ff == S_DIV_START);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   jet_mul u_jet_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod)
   );

   jet_div u_jet_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[DIVIDEND_W-1:0]),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      axis_in      = axis_ff;
      first_in     = first_ff;
      iter_in      = iter_ff;
      limit_in     = limit_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      sqr_in       = sqr_ff;
      sqi_in       = sqi_ff;
      res_shade_in = res_shade_ff;
      res_esc_in   = res_esc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_shade_in = rsp_shade_ff;
      rsp_esc_in   = rsp_esc_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               axis_in  = 1'b0;
               first_in = 1'b1;
               iter_in  = ITER_W'(1);
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            state_in = S_MAP_MUL;
         end
         S_MAP_MUL: begin
            // The product register still holds radius squared on the first axis.
            if (!axis_ff) begin
               limit_in = prod[LIMIT_W-1:0];
            end
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (!axis_ff) begin
                  zr_in    = mapped;
                  axis_in  = 1'b1;
                  state_in = S_MAP_MUL;
               end else begin
                  zi_in = mapped;
                  if (max_iter_ff == '0) begin
                     res_shade_in = '0;
                     res_esc_in   = 1'b0;
                     state_in     = S_FINISH;
                  end else begin
                     state_in = S_MUL_RR;
                  end
               end
            end
         end
         S_MUL_RR: begin
            state_in = S_MUL_II;
         end
         S_MUL_II: begin
            sqr_in   = prod;
            state_in = S_MUL_RI;
         end
         S_MUL_RI: begin
            sqi_in = prod;
            // The squares of the new point double as the escape test of the last update.
            priority if (first_ff) begin
               first_in = 1'b0;
               state_in = S_UPDATE;
            end else if (escape_hit) begin
               res_shade_in = iter_ff[SHADE_W-1:0];
               res_esc_in   = 1'b1;
               state_in     = S_FINISH;
            end else if (iter_ff == max_iter_ff) begin
               res_shade_in = '0;
               res_esc_in   = 1'b0;
               state_in     = S_FINISH;
            end else begin
               iter_in  = iter_ff + 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            zr_in    = sat_q(re_sum);
            zi_in    = sat_q(im_sum);
            state_in = S_MUL_RR;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_shade_in = res_shade_ff;
               rsp_esc_in   = res_esc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         first_ff     <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         first_ff     <= first_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      limit_ff     <= limit_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      sqr_ff       <= sqr_in;
      sqi_ff       <= sqi_in;
      res_shade_ff <= res_shade_in;
      res_esc_ff   <= res_esc_in;
      rsp_shade_ff <= rsp_shade_in;
      rsp_esc_ff   <= rsp_esc_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_shade   = rsp_shade_ff;
   assign rsp_escaped = rsp_esc_ff;

endmodule

[rtl/core/jet_checker.sv]
// Port-level checks of the Julia escape-time pixel evaluator, bound to its top level.
`timescale 1ns / 1ps

module jet_checker
   import jet_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SHADE_W-1:0] rsp_shade,
   input logic               rsp_escaped
);

   // Once a request is taken the block is busy with it and no longer ready.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block ready right after taking a request");

   // A point that never escaped reports shade zero.
   a_shade_zero_unescaped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_escaped) |-> (rsp_shade == '0))
      else $error("nonzero shade on a point that did not escape");

   // No result can appear in the cycle after a request is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared right after a request");

   // A stalled result holds its value.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_shade) && $stable(rsp_escaped)))
      else $error("stalled result changed or dropped");

endmodule

bind julia_escape_time_pixel jet_checker u_jet_checker (.*);
